// ----- rtl/dtwa_pkg.sv -----
// ----------------------------------------------------------------------------
// Discovery table package
// Shared sizes, codes and controller/datapath interface types.
// ----------------------------------------------------------------------------
package dtwa_pkg;

  localparam int TABLE_ENTRIES = 16;
  localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);

  localparam int IP_W      = 32;
  localparam int PORT_W    = 16;
  localparam int LEN_W     = 11;
  localparam int WORD_W    = 32;
  localparam int MS_W      = 32;
  localparam int SLOT_W    = 4;
  localparam int ENTRIES_W = 5;
  localparam int REMOVED_W = 5;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 32;
  localparam int IN_DATA_W  = 128;
  localparam int OUT_DATA_W = 16;

  localparam logic [WORD_W-1:0] PROTOCOL_ID_RESET = '0;
  localparam logic [LEN_W-1:0]  MIN_BYTES_RESET   = LEN_W'(10);
  localparam logic [MS_W-1:0]   TIMEOUT_RESET     = MS_W'(5000);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PROTOCOL_ID = 2'd0,
    REG_MIN_BYTES   = 2'd1,
    REG_TIMEOUT     = 2'd2
  } cfg_reg_t;

  typedef enum logic [2:0] {
    ST_TOO_SHORT = 3'd0,
    ST_BAD_PROTO = 3'd1,
    ST_REFRESHED = 3'd2,
    ST_ADDED     = 3'd3,
    ST_FULL      = 3'd4,
    ST_SWEEP     = 3'd5
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DONE
  } state_t;

  typedef struct packed {
    logic [IP_W-1:0]   ip;
    logic [PORT_W-1:0] port;
    logic [MS_W-1:0]   stamp;
  } entry_t;

  typedef struct packed {
    logic    load;
    logic    scan;
    logic    emit;
    status_t code;
  } ctrl_cmd_t;

  typedef struct packed {
    logic is_sweep;
    logic too_short;
    logic bad_proto;
    logic hit;
    logic free_found;
    logic chk_hit;
    logic chk_last;
    logic out_free;
  } dp_status_t;

endpackage

// ----- rtl/dtwa_ctrl.sv -----
// ----------------------------------------------------------------------------
// Discovery table controller
// Sequences load, table walk and result for one transaction at a time.
// ----------------------------------------------------------------------------
module dtwa_ctrl import dtwa_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  dp_status_t sts,
  output ctrl_cmd_t  cmd
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    s_tready   = 1'b0;
    cmd        = '{load: 1'b0, scan: 1'b0, emit: 1'b0, code: ST_TOO_SHORT};
    unique case (state)
      S_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          cmd.load   = 1'b1;
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        if (!sts.is_sweep && (sts.too_short || sts.bad_proto)) begin
          state_next = S_DONE;
        end else begin
          cmd.scan = 1'b1;
          if (sts.chk_hit || sts.chk_last) state_next = S_DONE;
        end
      end
      S_DONE: begin
        // length check wins over protocol check
        priority if (sts.is_sweep)   cmd.code = ST_SWEEP;
        else if (sts.too_short)      cmd.code = ST_TOO_SHORT;
        else if (sts.bad_proto)      cmd.code = ST_BAD_PROTO;
        else if (sts.hit)            cmd.code = ST_REFRESHED;
        else if (sts.free_found)     cmd.code = ST_ADDED;
        else                         cmd.code = ST_FULL;
        if (sts.out_free) begin
          cmd.emit   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

// ----- rtl/dtwa_dpath.sv -----
// ----------------------------------------------------------------------------
// Discovery table datapath
// Config registers, item registers, entry memory, walk pipeline, result register.
// ----------------------------------------------------------------------------
module dtwa_dpath import dtwa_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_valid,
  input  logic [CFG_IDX_W-1:0]  cfg_addr,
  input  logic [CFG_DAT_W-1:0]  cfg_data,
  input  logic                  s_tuser,
  input  logic [IN_DATA_W-1:0]  s_tdata,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [2:0]            m_tuser,
  output logic [OUT_DATA_W-1:0] m_tdata,
  input  ctrl_cmd_t             cmd,
  output dp_status_t            sts
);

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);

  logic [WORD_W-1:0] protocol_id;
  logic [LEN_W-1:0]  min_bytes;
  logic [MS_W-1:0]   timeout;

  logic              mode;
  logic [IP_W-1:0]   ip;
  logic [PORT_W-1:0] port;
  logic [LEN_W-1:0]  len;
  logic [WORD_W-1:0] word;
  logic [MS_W-1:0]   now;

  entry_t                   mem [TABLE_ENTRIES];
  entry_t                   rdata;
  logic [TABLE_ENTRIES-1:0] valid;
  logic [CNT_W-1:0]         count, count_next;

  logic [IDX_W-1:0] rd_idx, chk_idx, hit_idx, free_idx;
  logic             issued_all, chk_en, hit, free_found;
  logic [CNT_W-1:0] gone;

  logic [SLOT_W-1:0]    out_slot;
  logic [ENTRIES_W-1:0] out_entries;
  logic [REMOVED_W-1:0] out_removed;
  logic [2:0]           out_status;

  logic             chk_valid, key_match, chk_hit, chk_free, sweep_kill, adding;
  logic [MS_W-1:0]  age;
  logic             mem_we;
  logic [IDX_W-1:0] mem_waddr;
  logic [IDX_W-1:0] slot_sel;

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      protocol_id <= PROTOCOL_ID_RESET;
      min_bytes   <= MIN_BYTES_RESET;
      timeout     <= TIMEOUT_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_addr)
        REG_PROTOCOL_ID: protocol_id <= cfg_data;
        REG_MIN_BYTES:   min_bytes   <= cfg_data[LEN_W-1:0];
        REG_TIMEOUT:     timeout     <= cfg_data;
        default: ;
      endcase
    end
  end

  // item capture
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mode <= s_tuser;
      ip   <= s_tdata[31:0];
      port <= s_tdata[47:32];
      len  <= s_tdata[58:48];
      word <= s_tdata[90:59];
      now  <= s_tdata[122:91];
    end
  end

  // check stage works on the entry read in the previous cycle
  assign chk_valid  = chk_en && valid[chk_idx];
  assign key_match  = (rdata.ip == ip) && (rdata.port == port);
  assign chk_hit    = chk_valid && !mode && key_match;
  assign chk_free   = chk_en && !valid[chk_idx] && !mode && !free_found;
  assign age        = now - rdata.stamp;
  assign sweep_kill = chk_valid && mode && (age > timeout);
  assign adding     = cmd.emit && (cmd.code == ST_ADDED);

  assign mem_we    = (cmd.scan && chk_hit) || adding;
  assign mem_waddr = adding ? free_idx : chk_idx;

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= '{ip: ip, port: port, stamp: now};
    if (cmd.scan && !issued_all) rdata <= mem[rd_idx];
  end

  // walk pipeline
  always_ff @(posedge clk) begin
    if (rst) begin
      issued_all <= 1'b0;
      chk_en     <= 1'b0;
      hit        <= 1'b0;
      free_found <= 1'b0;
      gone       <= '0;
      rd_idx     <= '0;
    end else if (cmd.load) begin
      issued_all <= 1'b0;
      chk_en     <= 1'b0;
      hit        <= 1'b0;
      free_found <= 1'b0;
      gone       <= '0;
      rd_idx     <= '0;
    end else if (cmd.scan) begin
      chk_en  <= !issued_all;
      chk_idx <= rd_idx;
      if (!issued_all) begin
        rd_idx <= rd_idx + IDX_W'(1);
        if (rd_idx == LAST_IDX) issued_all <= 1'b1;
      end
      if (chk_hit) begin
        hit     <= 1'b1;
        hit_idx <= chk_idx;
      end
      if (chk_free) begin
        free_found <= 1'b1;
        free_idx   <= chk_idx;
      end
      if (sweep_kill) gone <= gone + CNT_W'(1);
    end
  end

  always_comb begin
    count_next = count;
    if (adding) count_next = count + CNT_W'(1);
    else if (cmd.emit && cmd.code == ST_SWEEP) count_next = count - gone;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
      count <= '0;
    end else begin
      if (cmd.scan && sweep_kill) valid[chk_idx] <= 1'b0;
      if (adding) valid[free_idx] <= 1'b1;
      count <= count_next;
    end
  end

  // result register
  always_comb begin
    unique case (cmd.code)
      ST_REFRESHED: slot_sel = hit_idx;
      ST_ADDED:     slot_sel = free_idx;
      default:      slot_sel = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.emit) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_status  <= cmd.code;
      out_slot    <= SLOT_W'(slot_sel);
      out_entries <= ENTRIES_W'(count_next);
      out_removed <= (cmd.code == ST_SWEEP) ? REMOVED_W'(gone) : '0;
    end
  end

  assign m_tuser = out_status;
  assign m_tdata = {2'b00, out_removed, out_entries, out_slot};

  assign sts = '{
    is_sweep:   mode,
    too_short:  (len <= min_bytes),
    bad_proto:  (word != protocol_id),
    hit:        hit,
    free_found: free_found,
    chk_hit:    chk_hit,
    chk_last:   chk_en && (chk_idx == LAST_IDX),
    out_free:   !m_tvalid || m_tready
  };

endmodule

// ----- rtl/discovery_table_with_aging.sv -----
// ----------------------------------------------------------------------------
// Discovery table with aging
// Learns servers by source address and port from beacons and ages them out.
// ----------------------------------------------------------------------------
// Input stream: s_tuser = 0 for a beacon, 1 for a sweep; s_tdata carries
// address, port, length, protocol word and the current time in ms.
// Output stream: one result per input transaction, status in m_tuser,
// slot, entry count and removed count in m_tdata.
// Config channel: cfg_addr selects protocol word, minimum length or timeout;
// cfg_ready is always high. Write only while no transaction is in flight.
// One transaction is handled at a time. A dropped beacon skips the walk and
// goes straight to its result; a lookup, add or sweep walks the entry memory
// one entry a cycle through a registered read, and a lookup stops early on a
// hit. s_tready rises again the cycle after the result is loaded.
// The result sits in an output register; if m_tready is low the next
// transaction is still accepted and walked, and waits only to hand over.
// Reset empties the table (valid bits cleared at once) and restores the
// configuration defaults; no clearing pass is needed.
// ----------------------------------------------------------------------------
module discovery_table_with_aging import dtwa_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_addr,
  input  logic [CFG_DAT_W-1:0]  cfg_data,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  // src_ip[31:0], src_port[47:32], packet_bytes[58:48], proto_word[90:59],
  // now_ms[122:91], zero fill above
  input  logic [IN_DATA_W-1:0]  s_tdata,
  input  logic                  s_tuser,   // mode[0]
  output logic                  m_tvalid,
  input  logic                  m_tready,
  // slot[3:0], entries[8:4], removed[13:9], zero fill above
  output logic [OUT_DATA_W-1:0] m_tdata,
  output logic [2:0]            m_tuser    // status[2:0]
);

  ctrl_cmd_t  cmd;
  dp_status_t sts;

  assign cfg_ready = 1'b1;

  dtwa_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  dtwa_dpath u_dpath (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_addr  (cfg_addr),
    .cfg_data  (cfg_data),
    .s_tuser   (s_tuser),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tuser   (m_tuser),
    .m_tdata   (m_tdata),
    .cmd       (cmd),
    .sts       (sts)
  );

  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("second transaction accepted while one is in flight");

  a_emit_free: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> sts.out_free)
    else $error("result loaded over one not yet taken");

  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(cmd.emit))
    else $error("result appeared without an emit");

  a_removed_sweep: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && (m_tuser != ST_SWEEP)) |-> (m_tdata[13:9] == 5'd0))
    else $error("removed count on a beacon result");

endmodule

// ----- test/tb_discovery_table_with_aging.sv -----
// ----------------------------------------------------------------------------
// Discovery table with aging: stream testbench
// Feeds beacon and sweep transactions through the input stream with random
// gaps, drains results with random back-pressure and checks each one
// against a local model of the server table, its aging and the
// configuration registers, over several register settings.
// ----------------------------------------------------------------------------
module tb_discovery_table_with_aging;
  import dtwa_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int TAIL_CYCLES    = 2 * TABLE_ENTRIES + 8;
  localparam int POOL_MAX       = 32;

  typedef struct packed {
    logic              mode;
    logic [IP_W-1:0]   ip;
    logic [PORT_W-1:0] port;
    logic [LEN_W-1:0]  len;
    logic [WORD_W-1:0] word;
    logic [MS_W-1:0]   now;
  } table_item_t;

  typedef struct packed {
    status_t              status;
    logic [SLOT_W-1:0]    slot;
    logic [ENTRIES_W-1:0] entries;
    logic [REMOVED_W-1:0] removed;
  } outcome_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_addr = '0;
  logic [CFG_DAT_W-1:0]  cfg_data = '0;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata = '0;
  logic                  s_tuser = 1'b0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;
  logic [2:0]            m_tuser;

  // model of the table and of the registers
  logic              tbl_valid [TABLE_ENTRIES] = '{default: 1'b0};
  logic [IP_W-1:0]   tbl_ip    [TABLE_ENTRIES];
  logic [PORT_W-1:0] tbl_port  [TABLE_ENTRIES];
  logic [MS_W-1:0]   tbl_time  [TABLE_ENTRIES];
  int                tbl_count = 0;
  logic [WORD_W-1:0] model_proto = PROTOCOL_ID_RESET;
  logic [LEN_W-1:0]  model_min   = MIN_BYTES_RESET;
  logic [MS_W-1:0]   model_tmo   = TIMEOUT_RESET;

  table_item_t beacon_queue[$];
  outcome_t    outcome_queue[$];
  table_item_t held_item;
  bit          item_held = 1'b0;
  int          send_gap = 0;
  int          take_gap = 0;
  bit          send_rush = 1'b0;
  bit          take_rush = 1'b0;
  int          fail_count = 0;
  int          idle_cycles = 0;

  // key pool and running clock for the random part
  logic [IP_W-1:0]   pool_ip   [POOL_MAX];
  logic [PORT_W-1:0] pool_port [POOL_MAX];
  int                pool_n = 1;
  logic [MS_W-1:0]   clock_ms = '0;

  discovery_table_with_aging u_top (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_addr  (cfg_addr),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),   // src_ip, src_port, packet_bytes, proto_word, now_ms
    .s_tuser   (s_tuser),   // mode
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),   // slot, entries, removed
    .m_tuser   (m_tuser)    // status
  );

  always #5 clk = ~clk;

  // Updates the table model for one transaction and returns its result.
  function automatic outcome_t table_outcome(table_item_t it);
    outcome_t        o;
    logic [MS_W-1:0] age;
    int              gone;
    bit              done;
    o.status  = ST_TOO_SHORT;
    o.slot    = '0;
    o.removed = '0;
    gone = 0;
    done = 1'b0;
    if (it.mode) begin
      for (int i = 0; i < TABLE_ENTRIES; i++) begin
        age = it.now - tbl_time[i];   // modular age
        if (tbl_valid[i] && age > model_tmo) begin
          tbl_valid[i] = 1'b0;
          gone++;
        end
      end
      tbl_count -= gone;
      o.status  = ST_SWEEP;
      o.removed = REMOVED_W'(gone);
    end else if (it.len <= model_min) begin
      o.status = ST_TOO_SHORT;
    end else if (it.word != model_proto) begin
      o.status = ST_BAD_PROTO;
    end else begin
      o.status = ST_FULL;
      for (int i = 0; i < TABLE_ENTRIES; i++) begin
        if (!done && tbl_valid[i] && tbl_ip[i] == it.ip && tbl_port[i] == it.port) begin
          tbl_time[i] = it.now;
          o.status = ST_REFRESHED;
          o.slot   = SLOT_W'(i);
          done = 1'b1;
        end
      end
      for (int i = 0; i < TABLE_ENTRIES; i++) begin
        if (!done && !tbl_valid[i]) begin
          tbl_valid[i] = 1'b1;
          tbl_ip[i]    = it.ip;
          tbl_port[i]  = it.port;
          tbl_time[i]  = it.now;
          tbl_count++;
          o.status = ST_ADDED;
          o.slot   = SLOT_W'(i);
          done = 1'b1;
        end
      end
    end
    o.entries = ENTRIES_W'(tbl_count);
    return o;
  endfunction

  function automatic table_item_t beacon_item(logic mode, logic [IP_W-1:0] ip,
                                              logic [PORT_W-1:0] port, logic [LEN_W-1:0] len,
                                              logic [WORD_W-1:0] word, logic [MS_W-1:0] now);
    table_item_t it;
    it.mode = mode;
    it.ip   = ip;
    it.port = port;
    it.len  = len;
    it.word = word;
    it.now  = now;
    return it;
  endfunction

  // appends one transaction to the pending list of the driver
  function automatic void queue_item(table_item_t it);
    beacon_queue = {beacon_queue, it};
  endfunction

  // driver: one transaction held at a time, random gap after each
  always @(posedge clk) begin : drive_proc
    logic next_valid;
    if (rst) begin
      s_tvalid <= 1'b0;
      send_gap = 0;
    end else begin
      next_valid = s_tvalid;
      if (s_tvalid && s_tready) begin
        outcome_queue = {outcome_queue, table_outcome(held_item)};
        item_held  = 1'b0;
        next_valid = 1'b0;
        if ($urandom_range(0, 24) == 0) send_rush = !send_rush;
        send_gap = send_rush ? 0 : $urandom_range(0, 9);
      end
      if (!next_valid) begin
        if (send_gap > 0) begin
          send_gap--;
        end else if (beacon_queue.size() > 0) begin
          held_item = beacon_queue.pop_front();
          item_held = 1'b1;
          s_tdata <= {5'b0, held_item.now, held_item.word, held_item.len,
                      held_item.port, held_item.ip};
          s_tuser <= held_item.mode;
          next_valid = 1'b1;
        end
      end
      s_tvalid <= next_valid;
    end
  end

  // monitor: checks each result, then stalls for a random while
  always @(posedge clk) begin : watch_proc
    logic     next_ready;
    outcome_t want;
    if (rst) begin
      m_tready <= 1'b0;
      take_gap = 0;
    end else begin
      next_ready = m_tready;
      if (m_tvalid && m_tready) begin
        if (outcome_queue.size() == 0) begin
          $error("result with nothing expected: status %0d tdata %h", m_tuser, m_tdata);
          fail_count++;
        end else begin
          want = outcome_queue.pop_front();
          if (m_tuser !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, m_tuser);
            fail_count++;
          end
          if (m_tdata[3:0] !== want.slot) begin
            $error("slot: expected %0d, got %0d", want.slot, m_tdata[3:0]);
            fail_count++;
          end
          if (m_tdata[8:4] !== want.entries) begin
            $error("entries: expected %0d, got %0d", want.entries, m_tdata[8:4]);
            fail_count++;
          end
          if (m_tdata[13:9] !== want.removed) begin
            $error("removed: expected %0d, got %0d", want.removed, m_tdata[13:9]);
            fail_count++;
          end
        end
        if ($urandom_range(0, 24) == 0) take_rush = !take_rush;
        take_gap = take_rush ? 0 : $urandom_range(0, 9);
        if (take_gap > 0) next_ready = 1'b0;
      end else if (!m_tready) begin
        if (take_gap > 0) take_gap--;
        if (take_gap == 0) next_ready = 1'b1;
      end
      m_tready <= next_ready;
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("tb_discovery_table_with_aging NOT OK");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic wait_drained();
    while (beacon_queue.size() != 0 || item_held || outcome_queue.size() != 0)
      @(posedge clk);
  endtask

  // leaves cfg_valid high; the caller lowers it after the last write
  task automatic put_reg(input cfg_reg_t r, input logic [CFG_DAT_W-1:0] v);
    cfg_valid <= 1'b1;
    cfg_addr  <= r;
    cfg_data  <= v;
    do @(posedge clk); while (!(cfg_valid && cfg_ready));
    case (r)
      REG_PROTOCOL_ID: model_proto = v;
      REG_MIN_BYTES:   model_min   = v[LEN_W-1:0];
      REG_TIMEOUT:     model_tmo   = v;
      default: ;
    endcase
  endtask

  task automatic run_phase(input logic [WORD_W-1:0] proto, input logic [LEN_W-1:0] min_len,
                           input logic [MS_W-1:0] tmo, input int count);
    table_item_t     it;
    logic [MS_W-1:0] span;
    int              roll;
    int              k;
    wait_drained();
    put_reg(REG_TIMEOUT, tmo);
    put_reg(REG_PROTOCOL_ID, proto);
    put_reg(REG_MIN_BYTES, CFG_DAT_W'(min_len));
    cfg_valid <= 1'b0;

    // some keys share an address or a port with their neighbour
    pool_n = $urandom_range(4, 28);
    for (int p = 0; p < pool_n; p++) begin
      pool_ip[p]   = $urandom;
      pool_port[p] = PORT_W'($urandom);
      if (p > 0 && $urandom_range(0, 3) == 0) pool_ip[p] = pool_ip[p-1];
      else if (p > 0 && $urandom_range(0, 3) == 0) pool_port[p] = pool_port[p-1];
    end

    span = (tmo >> 3) + 32'd3;
    if ($urandom_range(0, 1) == 0) clock_ms = $urandom;
    else clock_ms = 32'hFFFF_FFFF - 32'($urandom_range(0, span)) * 32'd20;  // wraps soon

    for (int n = 0; n < count; n++) begin
      if ($urandom_range(0, 19) == 0) clock_ms = $urandom;
      else clock_ms += 32'($urandom_range(0, span));
      roll    = $urandom_range(0, 99);
      it.now  = clock_ms;
      it.ip   = $urandom;
      it.port = PORT_W'($urandom);
      it.len  = LEN_W'($urandom);
      it.word = $urandom;
      it.mode = (roll < 15);
      if (roll >= 15 && roll < 85) begin
        k = $urandom_range(0, pool_n - 1);
        it.ip   = pool_ip[k];
        it.port = pool_port[k];
        it.word = proto;
        if (min_len < 11'd2047) it.len = LEN_W'($urandom_range(int'(min_len) + 1, 2047));
      end else if (roll >= 85 && roll < 92) begin
        it.len = LEN_W'($urandom_range(0, int'(min_len)));
      end else if (roll >= 92 && roll < 97) begin
        k = $urandom_range(0, pool_n - 1);
        it.ip   = pool_ip[k];
        it.port = pool_port[k];
        it.word = proto ^ (32'd1 << $urandom_range(0, 31));
      end
      queue_item(it);
    end
  endtask

  initial begin : stim_proc
    logic [MS_W-1:0]   t0;
    logic [IP_W-1:0]   fill_ip;
    logic [PORT_W-1:0] fill_port;
    logic [MS_W-1:0]   tmo;
    logic [LEN_W-1:0]  min_len;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // directed part, on the reset register values
    t0 = 32'd1000;
    queue_item(beacon_item(1'b0, 32'h0A00_0001, 16'd5000, 11'd10, 32'h0, t0));
    // short and of the wrong protocol: the length check wins
    queue_item(beacon_item(1'b0, 32'h0A00_0001, 16'd5000, 11'd0, 32'hFFFF_FFFF, t0));
    queue_item(beacon_item(1'b0, 32'h0A00_0001, 16'd5000, 11'd2047, 32'hFFFF_FFFF, t0));
    queue_item(beacon_item(1'b0, 32'h0A00_0001, 16'd5000, 11'd11, 32'h0, t0));
    queue_item(beacon_item(1'b0, 32'h0A00_0001, 16'd5000, 11'd2047, 32'h0, t0 + 100));
    queue_item(beacon_item(1'b0, 32'h0A00_0001, 16'd5001, 11'd200, 32'h0, t0 + 100));
    queue_item(beacon_item(1'b0, 32'h0A00_0002, 16'd5000, 11'd200, 32'h0, t0 + 100));
    // age equal to the timeout keeps the entries; fields besides the time ignored
    queue_item(beacon_item(1'b1, 32'hFFFF_FFFF, 16'hFFFF, 11'h7FF, 32'hFFFF_FFFF,
                           t0 + 5100));
    queue_item(beacon_item(1'b1, 32'h0, 16'h0, 11'h0, 32'h0, t0 + 5101));
    // fill the table, one more beacon finds it full
    for (int i = 0; i <= TABLE_ENTRIES; i++) begin
      fill_ip   = 32'hC0A8_0000 + 32'(i);
      fill_port = 16'(1000 + i);
      if (i == 0) begin
        fill_ip   = 32'h0;
        fill_port = 16'h0;
      end else if (i == 1) begin
        fill_ip   = 32'hFFFF_FFFF;
        fill_port = 16'hFFFF;
      end
      queue_item(beacon_item(1'b0, fill_ip, fill_port, 11'd11, 32'h0, t0 + 6000));
    end
    queue_item(beacon_item(1'b1, 32'h0, 16'h0, 11'h0, 32'h0, t0 + 11001));

    // extremes first, then random settings
    run_phase(32'h0, 11'd0, 32'h0, 105);
    run_phase(32'hFFFF_FFFF, 11'd2047, 32'hFFFF_FFFF, 40);
    for (int p = 0; p < 8; p++) begin
      case ($urandom_range(0, 2))
        0:       tmo = $urandom_range(0, 60);
        1:       tmo = $urandom_range(1000, 20000);
        default: tmo = $urandom;
      endcase
      if ($urandom_range(0, 2) == 0) min_len = LEN_W'($urandom_range(0, 2047));
      else min_len = LEN_W'($urandom_range(0, 64));
      run_phase($urandom, min_len, tmo, 105);
    end
    // nothing ever ages out here, so the table stays full for long stretches
    run_phase($urandom, 11'd1, 32'hFFFF_FFFF, 105);

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("tb_discovery_table_with_aging OK");
    end else begin
      $display("tb_discovery_table_with_aging NOT OK");
    end
    $finish;
  end

endmodule

// ----- discovery_table_with_aging.f -----
rtl/dtwa_pkg.sv
rtl/dtwa_ctrl.sv
rtl/dtwa_dpath.sv
rtl/discovery_table_with_aging.sv
test/tb_discovery_table_with_aging.sv
